// ----- src/srtf_pkg.sv -----
// Package for the shortest-remaining-time-first tick scheduler.
// Holds the sequencer state type, the result status codes and the fixed field widths.
// No dependencies.
package srtf_pkg;

    localparam int JOB_W    = 8;
    localparam int BURST_W  = 16;
    localparam int OUT_T_W  = 16;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADMITTED   = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_ZERO_BURST = 3'd2,
        STAT_RAN        = 3'd3,
        STAT_IDLE_TICK  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DEC,
        S_TAT,
        S_WAIT,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

// ----- src/srtf_tick_scheduler.sv -----
// Top level of the shortest-remaining-time-first tick scheduler.
// Depends on srtf_pkg, srtf_mem (slot table) and srtf_alu (shared subtractor).
//
// Usage: an input beat carries a command. An arrival (cmd 0) admits a job with its
// burst into the table, stamped with the current time; a zero burst or a full table
// is rejected. A tick (cmd 1) runs the held job with the least remaining time, the
// earlier admitted one on a tie, decrements it and advances the saturating time.
// Every input beat gives exactly one output beat carrying the status, the job that
// ran and, when it completed, its completion, turnaround and waiting times.
// Jobs are kept in admission order in the table; a completed job is removed by
// moving each later entry down one place, one entry per cycle.
// Sequence: an arrival or an idle tick goes straight to the done state, which loads the
// output register once it is free. A tick that runs a job scans the N held jobs one per
// cycle through the table's read port, then decrements the chosen one. When the job
// completes, the turnaround and waiting times follow and each later entry moves down.
// The input is taken only while no item is in work; one result may wait in the
// output register while the next item is accepted. If the receiver stalls, a
// further result is held back until the output register is free.
// Reset empties the table and clears the time and the output valid.
module srtf_tick_scheduler #(
    parameter int SLOTS      = 16,
    parameter int TIME_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_job_id,
    input  logic [15:0] i_burst_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_ran_id,
    output logic        o_finished,
    output logic [15:0] o_completion_time,
    output logic [15:0] o_turnaround,
    output logic [15:0] o_waiting,
    output logic [15:0] o_time_now
);

    localparam int TW    = TIME_WIDTH;
    localparam int BW    = srtf_pkg::BURST_W;
    localparam int JW    = srtf_pkg::JOB_W;
    localparam int OW    = srtf_pkg::OUT_T_W;
    localparam int AW    = (TW > BW) ? TW : BW;
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int EW    = JW + BW + TW + BW;
    localparam int ARR_L = BW;
    localparam int REM_L = BW + TW;
    localparam int JOB_L = BW + TW + BW;

    srtf_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [TW-1:0]     r_time, n_time;
    logic [IW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_best, n_best;
    logic [JW-1:0]     r_best_job, n_best_job;
    logic [BW-1:0]     r_best_rem, n_best_rem;
    logic [TW-1:0]     r_best_arr, n_best_arr;
    logic [BW-1:0]     r_best_burst, n_best_burst;
    srtf_pkg::t_status r_status, n_status;
    logic [JW-1:0]     r_ran, n_ran;
    logic              r_fin, n_fin;
    logic [TW-1:0]     r_comp, n_comp;
    logic [AW-1:0]     r_tat, n_tat;
    logic [AW-1:0]     r_wait, n_wait;

    logic              r_o_valid, n_o_valid;
    srtf_pkg::t_status r_o_status, n_o_status;
    logic [JW-1:0]     r_o_ran, n_o_ran;
    logic              r_o_fin, n_o_fin;
    logic [OW-1:0]     r_o_comp, n_o_comp;
    logic [OW-1:0]     r_o_tat, n_o_tat;
    logic [OW-1:0]     r_o_wait, n_o_wait;
    logic [OW-1:0]     r_o_time, n_o_time;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [EW-1:0]     w_wdata;
    logic [IW-1:0]     w_raddr;
    logic [EW-1:0]     w_rdata;
    logic [AW-1:0]     w_alu_a;
    logic [AW-1:0]     w_alu_b;
    logic [AW-1:0]     w_alu_diff;
    logic              w_alu_lt;
    logic [TW-1:0]     w_time_inc;
    logic [CW-1:0]     w_last;
    logic              w_at_last;
    logic [BW-1:0]     w_rem_new;

    srtf_mem #(
        .DEPTH (SLOTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    srtf_alu #(
        .W (AW)
    ) u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .o_diff (w_alu_diff),
        .o_lt   (w_alu_lt)
    );

    assign w_time_inc = (r_time == {TW{1'b1}}) ? r_time : r_time + TW'(1);
    assign w_last     = r_count - CW'(1);
    assign w_at_last  = (CW'(r_idx) == w_last);
    assign w_rem_new  = w_alu_diff[BW-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_time       = r_time;
        n_idx        = r_idx;
        n_best       = r_best;
        n_best_job   = r_best_job;
        n_best_rem   = r_best_rem;
        n_best_arr   = r_best_arr;
        n_best_burst = r_best_burst;
        n_status     = r_status;
        n_ran        = r_ran;
        n_fin        = r_fin;
        n_comp       = r_comp;
        n_tat        = r_tat;
        n_wait       = r_wait;
        n_o_valid    = r_o_valid & ~i_out_ready;
        n_o_status   = r_o_status;
        n_o_ran      = r_o_ran;
        n_o_fin      = r_o_fin;
        n_o_comp     = r_o_comp;
        n_o_tat      = r_o_tat;
        n_o_wait     = r_o_wait;
        n_o_time     = r_o_time;
        w_we         = 1'b0;
        w_waddr      = r_best;
        w_wdata      = {r_best_job, w_rem_new, r_best_arr, r_best_burst};
        w_raddr      = '0;
        w_alu_a      = '0;
        w_alu_b      = '0;
        o_in_ready   = 1'b0;

        unique case (r_state)
            srtf_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                n_ran      = '0;
                n_fin      = 1'b0;
                n_comp     = '0;
                n_tat      = '0;
                n_wait     = '0;
                n_idx      = '0;
                if (i_in_valid) begin
                    n_state = srtf_pkg::S_DONE;
                    if (!i_cmd) begin
                        if (i_burst_len == '0) begin
                            n_status = srtf_pkg::STAT_ZERO_BURST;
                        end else if (r_count == CW'(SLOTS)) begin
                            n_status = srtf_pkg::STAT_FULL;
                        end else begin
                            n_status = srtf_pkg::STAT_ADMITTED;
                            w_we     = 1'b1;
                            w_waddr  = r_count[IW-1:0];
                            w_wdata  = {i_job_id, i_burst_len, r_time, i_burst_len};
                            n_count  = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_status = srtf_pkg::STAT_IDLE_TICK;
                        n_time   = w_time_inc;
                    end else begin
                        n_state = srtf_pkg::S_SCAN;
                    end
                end
            end

            srtf_pkg::S_SCAN: begin
                w_raddr = r_idx + IW'(1);
                w_alu_a = AW'(w_rdata[REM_L +: BW]);
                w_alu_b = AW'(r_best_rem);
                if (r_idx == '0 || w_alu_lt) begin
                    n_best       = r_idx;
                    n_best_job   = w_rdata[JOB_L +: JW];
                    n_best_rem   = w_rdata[REM_L +: BW];
                    n_best_arr   = w_rdata[ARR_L +: TW];
                    n_best_burst = w_rdata[BW-1:0];
                end
                n_idx = r_idx + IW'(1);
                if (w_at_last) begin
                    n_state = srtf_pkg::S_DEC;
                end
            end

            srtf_pkg::S_DEC: begin
                w_alu_a  = AW'(r_best_rem);
                w_alu_b  = AW'(1);
                n_time   = w_time_inc;
                n_status = srtf_pkg::STAT_RAN;
                n_ran    = r_best_job;
                if (w_rem_new != '0) begin
                    w_we    = 1'b1;
                    n_state = srtf_pkg::S_DONE;
                end else begin
                    n_fin   = 1'b1;
                    n_comp  = w_time_inc;
                    n_state = srtf_pkg::S_TAT;
                end
            end

            srtf_pkg::S_TAT: begin
                w_alu_a = AW'(r_time);
                w_alu_b = AW'(r_best_arr);
                n_tat   = w_alu_lt ? '0 : w_alu_diff;
                n_state = srtf_pkg::S_WAIT;
            end

            srtf_pkg::S_WAIT: begin
                w_alu_a = r_tat;
                w_alu_b = AW'(r_best_burst);
                n_wait  = w_alu_lt ? '0 : w_alu_diff;
                w_raddr = r_best + IW'(1);
                n_idx   = r_best + IW'(1);
                if (CW'(r_best) == w_last) begin
                    n_count = w_last;
                    n_state = srtf_pkg::S_DONE;
                end else begin
                    n_state = srtf_pkg::S_SHIFT;
                end
            end

            srtf_pkg::S_SHIFT: begin
                w_we    = 1'b1;
                w_waddr = r_idx - IW'(1);
                w_wdata = w_rdata;
                w_raddr = r_idx + IW'(1);
                n_idx   = r_idx + IW'(1);
                if (w_at_last) begin
                    n_count = w_last;
                    n_state = srtf_pkg::S_DONE;
                end
            end

            srtf_pkg::S_DONE: begin
                if (!r_o_valid || i_out_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_ran    = r_ran;
                    n_o_fin    = r_fin;
                    n_o_comp   = OW'(r_comp);
                    n_o_tat    = OW'(r_tat);
                    n_o_wait   = OW'(r_wait);
                    n_o_time   = OW'(r_time);
                    n_state    = srtf_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = srtf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= srtf_pkg::S_IDLE;
            r_count   <= '0;
            r_time    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_time    <= n_time;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_best       <= n_best;
        r_best_job   <= n_best_job;
        r_best_rem   <= n_best_rem;
        r_best_arr   <= n_best_arr;
        r_best_burst <= n_best_burst;
        r_status     <= n_status;
        r_ran        <= n_ran;
        r_fin        <= n_fin;
        r_comp       <= n_comp;
        r_tat        <= n_tat;
        r_wait       <= n_wait;
        r_o_status   <= n_o_status;
        r_o_ran      <= n_o_ran;
        r_o_fin      <= n_o_fin;
        r_o_comp     <= n_o_comp;
        r_o_tat      <= n_o_tat;
        r_o_wait     <= n_o_wait;
        r_o_time     <= n_o_time;
    end

    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_ran_id          = r_o_ran;
    assign o_finished        = r_o_fin;
    assign o_completion_time = r_o_comp;
    assign o_turnaround      = r_o_tat;
    assign o_waiting         = r_o_wait;
    assign o_time_now        = r_o_time;

endmodule

// ----- src/srtf_alu.sv -----
// Shared subtract and compare unit of the scheduler.
// Gives the difference of two unsigned operands and whether the first is below the second.
// No dependencies.
module srtf_alu #(
    parameter int W = 16
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W-1:0] o_diff,
    output logic         o_lt
);

    logic [W:0] w_full;

    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff = w_full[W-1:0];
    assign o_lt   = w_full[W];

endmodule

// ----- src/srtf_mem.sv -----
// Job slot table of the scheduler: one write port and one read port with registered read data.
// No dependencies.
module srtf_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 56
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
